[rtl/taylor_sine_cosine_core_defines.svh]
// ----------------------------------------------------------------------------
// taylor sine cosine core assertion macros
// shared concurrent assertion forms for the core checker
// ----------------------------------------------------------------------------
`ifndef TAYLOR_SINE_COSINE_CORE_DEFINES_SVH
`define TAYLOR_SINE_COSINE_CORE_DEFINES_SVH

// same-cycle implication
`define TSC_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsc check failed");

// next-cycle implication
`define TSC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsc check failed");

`endif

[rtl/tsc_pkg.sv]
// ----------------------------------------------------------------------------
// tsc package
// shared types and constants of the taylor sine cosine core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsc_pkg;

  localparam int unsigned ANGLE_W = 25;
  localparam int unsigned TOL_W   = 21;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned DEN_W   = 12;   // largest denominator 62*63
  localparam int unsigned DIGIT_W = 16;   // multiplier digit
  localparam int unsigned K_W     = 31;

  localparam logic [K_W-1:0]     DEG_TO_RAD_Q36 = 31'd1199381129;
  localparam logic [ANGLE_W-1:0] ANGLE_LIMIT    = 25'd23592960;  // 360 << 16
  localparam logic [TOL_W-1:0]   TOL_RESET      = 21'd1074;
  localparam logic [OUT_W-1:0]   ONE_Q30        = 32'h4000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,
    S_RND,
    S_SQR,
    S_SQR_W,
    S_MS,
    S_MS_W,
    S_MC,
    S_MC_W,
    S_DRAIN,
    S_FIN
  } tsc_state_e;

  typedef struct packed {
    logic valid;
    logic is_cos;
  } div_ctl_t;

endpackage

[rtl/tsc_div_cell.sv]
// ----------------------------------------------------------------------------
// tsc divider cell
// one restoring division step, registered, passes work to the next cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsc_div_cell import tsc_pkg::*; #(
  parameter int unsigned NW = 54
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_ctl_t          ctl_i,
  input  logic [NW-1:0]     num_i,
  input  logic [DEN_W-1:0]  rem_i,
  input  logic [NW-1:0]     quo_i,
  input  logic [DEN_W-1:0]  den_i,
  output div_ctl_t          ctl_o,
  output logic [NW-1:0]     num_o,
  output logic [DEN_W-1:0]  rem_o,
  output logic [NW-1:0]     quo_o,
  output logic [DEN_W-1:0]  den_o
);

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  div_ctl_t         ctl_q;
  logic [NW-1:0]    num_q, quo_q;
  logic [DEN_W-1:0] rem_q, den_q;

  assign trial = {rem_i, num_i[NW-1]};
  assign ge    = (trial >= {1'b0, den_i});
  assign diff  = trial - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= {num_i[NW-2:0], 1'b0};
    rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_q <= {quo_i[NW-2:0], ge};
    den_q <= den_i;
  end

  assign ctl_o = ctl_q;
  assign num_o = num_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign den_o = den_q;

endmodule

[rtl/tsc_mul.sv]
// ----------------------------------------------------------------------------
// tsc multiplier
// digit-serial multiply with rounding shift, round(a * b / 2^FRAC)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsc_mul import tsc_pkg::*; #(
  parameter int unsigned W    = 47,
  parameter int unsigned FRAC = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [W-1:0]          a_i,
  input  logic [W-1:0]          b_i,
  output logic                  done_o,
  output logic [2*W-FRAC-1:0]   res_o
);

  localparam int unsigned ND = (W + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned BP = ND * DIGIT_W;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned RW = PW - FRAC;
  localparam int unsigned CW = $clog2(ND + 1);
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC - 1);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [W-1:0]      a_q;
  logic [BP-1:0]     b_q;
  logic [PW-1:0]     acc_q;
  logic [RW-1:0]     res_q;
  logic [W+DIGIT_W-1:0] part;

  assign part = a_q * b_q[BP-1 -: DIGIT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ND);
      end else if (busy_q) begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - CW'(1);
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= BP'(b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        acc_q <= (acc_q << DIGIT_W) + PW'(part);
        b_q   <= b_q << DIGIT_W;
      end else begin
        res_q <= RW'((acc_q + HALF) >> FRAC);
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[rtl/taylor_sine_cosine_core.sv]
// schedule: an angle runs T term steps (1 to MAX_TERMS - 1) through the shared multiplier of
//   ND = ceil((ACC_FRAC_BITS+7)/16) digits and the divider chain of NW = ACC_FRAC_BITS + 14
//   cells; a step is shorter once one series has stopped; an angle above 360 degrees skips the
//   series and goes straight to the result
// input: a new angle is taken only once the last result is written; a stalled result holds the core in its last state
// reset: tolerance returns to 1074, no result pending, input ready
// ----------------------------------------------------------------------------
// taylor sine cosine core
// degrees to radians, then sine and cosine by taylor series in fixed point
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module taylor_sine_cosine_core import tsc_pkg::*; #(
  parameter int unsigned MAX_TERMS     = 24,
  parameter int unsigned ACC_FRAC_BITS = 40
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write, tolerance only
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [TOL_W-1:0]        cfg_data_i,
  // angle input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [ANGLE_W-1:0]      angle_degrees_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] sine_value_o,
  output logic signed [OUT_W-1:0] cosine_value_o,
  output logic                    out_of_range_o
);

  localparam int unsigned F    = ACC_FRAC_BITS;
  localparam int unsigned XW   = F + 3;    // radians, below 8
  localparam int unsigned X2W  = F + 6;    // x squared, below 64
  localparam int unsigned MW   = F + 7;    // term magnitude, below 128
  localparam int unsigned NW   = F + 14;   // dividend and quotient width
  localparam int unsigned SW   = F + 11;   // signed partial sums
  localparam int unsigned TW   = F - 9;    // tolerance at accumulator scale
  localparam int unsigned CVW  = ANGLE_W + K_W;
  localparam int unsigned CSH  = 52 - F;
  localparam int unsigned SH   = F - 30;
  localparam int unsigned NCW  = $clog2(MAX_TERMS);
  localparam logic [NCW-1:0] N_LAST = NCW'(MAX_TERMS - 1);
  localparam logic [CVW-1:0] CV_HALF = CVW'(1) << (CSH - 1);
  localparam logic [MW-1:0]  ONE_ACC = MW'(1) << F;

  tsc_state_e state_q, state_d;

  // control state
  logic              out_valid_q, out_valid_d;
  logic              oor_q, oor_d;
  logic              act_s_q, act_s_d, act_c_q, act_c_d;
  logic              neg_s_q, neg_s_d, neg_c_q, neg_c_d;
  logic [1:0]        outs_q, outs_d;
  logic [NCW-1:0]    n_q, n_d;
  logic [TOL_W-1:0]  tol_q;

  // payload
  logic [ANGLE_W-1:0]    angle_q, angle_d;
  logic [CVW-1:0]        conv_q, conv_d;
  logic [XW-1:0]         x_q, x_d;
  logic [X2W-1:0]        x2_q, x2_d;
  logic [MW-1:0]         mag_s_q, mag_s_d, mag_c_q, mag_c_d;
  logic signed [SW-1:0]  sum_s_q, sum_s_d, sum_c_q, sum_c_d;
  logic [OUT_W-1:0]      sin_o_q, sin_o_d, cos_o_q, cos_o_d;
  logic                  oor_o_q, oor_o_d;

  // shared multiplier
  logic              mul_start, mul_done;
  logic [MW-1:0]     mul_a, mul_b;
  logic [NW-1:0]     mul_res;

  // divider chain
  div_ctl_t          ctl_c [NW+1];
  logic [NW-1:0]     num_c [NW+1];
  logic [NW-1:0]     quo_c [NW+1];
  logic [DEN_W-1:0]  rem_c [NW+1];
  logic [DEN_W-1:0]  den_c [NW+1];

  // chain entry
  div_ctl_t          div_ctl;
  logic [NW-1:0]     div_num;
  logic [DEN_W-1:0]  div_den;

  logic [NCW:0]      two_n;
  logic [DEN_W-1:0]  den_s, den_c_w;
  logic [MW-1:0]     tol_m, q_ret;
  logic              issue, ret;

  function automatic logic [OUT_W-1:0] to_q30(input logic signed [SW-1:0] v);
    logic [SW-1:0]  m;
    logic [SW:0]    r;
    logic [SW-1:0]  q;
    logic [OUT_W-1:0] t;
    m = v[SW-1] ? (~v + 1'b1) : v;
    r = {m, 1'b0} + ((SW+1)'(1) << SH);
    q = SW'(r >> (SH + 1));
    if (q > SW'(ONE_Q30)) begin
      q = SW'(ONE_Q30);
    end
    t = OUT_W'(q);
    return v[SW-1] ? (~t + 1'b1) : t;
  endfunction

  tsc_mul #(
    .W    (MW),
    .FRAC (F)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // divider chain, one quotient bit per cell
  assign ctl_c[0] = div_ctl;
  assign num_c[0] = div_num;
  assign den_c[0] = div_den;
  assign rem_c[0] = '0;
  assign quo_c[0] = '0;

  for (genvar g = 0; g < NW; g++) begin : g_div
    tsc_div_cell #(
      .NW (NW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_c[g]),
      .num_i  (num_c[g]),
      .rem_i  (rem_c[g]),
      .quo_i  (quo_c[g]),
      .den_i  (den_c[g]),
      .ctl_o  (ctl_c[g+1]),
      .num_o  (num_c[g+1]),
      .rem_o  (rem_c[g+1]),
      .quo_o  (quo_c[g+1]),
      .den_o  (den_c[g+1])
    );
  end

  // denominators of term n: (2n)(2n+1) for sine, (2n)(2n-1) for cosine
  assign two_n   = {n_q, 1'b0};
  assign den_s   = DEN_W'(two_n) * (DEN_W'(two_n) + DEN_W'(1));
  assign den_c_w = DEN_W'(two_n) * (DEN_W'(two_n) - DEN_W'(1));

  assign tol_m = MW'(TW'(tol_q) << SH);
  assign ret   = ctl_c[NW].valid;
  assign q_ret = MW'(quo_c[NW]);

  assign mul_a = (state_q == S_SQR) ? MW'(x_q) : ((state_q == S_MS) ? mag_s_q : mag_c_q);
  assign mul_b = (state_q == S_SQR) ? MW'(x_q) : MW'(x2_q);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    oor_d       = oor_q;
    act_s_d     = act_s_q;
    act_c_d     = act_c_q;
    neg_s_d     = neg_s_q;
    neg_c_d     = neg_c_q;
    n_d         = n_q;
    angle_d     = angle_q;
    conv_d      = conv_q;
    x_d         = x_q;
    x2_d        = x2_q;
    mag_s_d     = mag_s_q;
    mag_c_d     = mag_c_q;
    sum_s_d     = sum_s_q;
    sum_c_d     = sum_c_q;
    sin_o_d     = sin_o_q;
    cos_o_d     = cos_o_q;
    oor_o_d     = oor_o_q;
    mul_start   = 1'b0;
    issue       = 1'b0;
    div_ctl     = '0;
    div_num     = mul_res + NW'(den_s >> 1);
    div_den     = den_s;

    // result transfer frees the output register
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // quotient returns: next term, sign flip, accumulate, tolerance check
    if (ret) begin
      if (ctl_c[NW].is_cos) begin
        mag_c_d = q_ret;
        neg_c_d = !neg_c_q;
        sum_c_d = neg_c_q ? sum_c_q + SW'(q_ret) : sum_c_q - SW'(q_ret);
        act_c_d = !(q_ret < tol_m);
      end else begin
        mag_s_d = q_ret;
        neg_s_d = !neg_s_q;
        sum_s_d = neg_s_q ? sum_s_q + SW'(q_ret) : sum_s_q - SW'(q_ret);
        act_s_d = !(q_ret < tol_m);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          angle_d = angle_degrees_i;
          oor_d   = 1'b0;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        if (angle_q > ANGLE_LIMIT) begin
          oor_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          conv_d  = angle_q * DEG_TO_RAD_Q36;
          state_d = S_RND;
        end
      end
      S_RND: begin
        x_d     = XW'((conv_q + CV_HALF) >> CSH);
        mag_s_d = MW'(x_d);
        sum_s_d = SW'(x_d);
        mag_c_d = ONE_ACC;
        sum_c_d = SW'(ONE_ACC);
        neg_s_d = 1'b0;
        neg_c_d = 1'b0;
        act_s_d = 1'b1;
        act_c_d = 1'b1;
        n_d     = NCW'(1);
        state_d = S_SQR;
      end
      S_SQR: begin
        mul_start = 1'b1;
        state_d   = S_SQR_W;
      end
      S_SQR_W: begin
        if (mul_done) begin
          x2_d    = X2W'(mul_res);
          state_d = S_MS;
        end
      end
      S_MS: begin
        if (act_s_q) begin
          mul_start = 1'b1;
          state_d   = S_MS_W;
        end else begin
          state_d = S_MC;
        end
      end
      S_MS_W: begin
        if (mul_done) begin
          issue   = 1'b1;
          div_ctl = '{valid: 1'b1, is_cos: 1'b0};
          state_d = S_MC;
        end
      end
      S_MC: begin
        if (act_c_q) begin
          mul_start = 1'b1;
          state_d   = S_MC_W;
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_MC_W: begin
        div_num = mul_res + NW'(den_c_w >> 1);
        div_den = den_c_w;
        if (mul_done) begin
          issue   = 1'b1;
          div_ctl = '{valid: 1'b1, is_cos: 1'b1};
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait for every outstanding quotient before the next term step
        if (outs_q == 2'd0) begin
          if ((n_q == N_LAST) || (!act_s_q && !act_c_q)) begin
            state_d = S_FIN;
          end else begin
            n_d     = n_q + NCW'(1);
            state_d = S_MS;
          end
        end
      end
      S_FIN: begin
        if (!(out_valid_q && out_stall_i)) begin
          sin_o_d     = oor_q ? '0 : to_q30(sum_s_q);
          cos_o_d     = oor_q ? '0 : to_q30(sum_c_q);
          oor_o_d     = oor_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    outs_d = outs_q;
    if (issue && !ret) begin
      outs_d = outs_q + 2'd1;
    end else if (ret && !issue) begin
      outs_d = outs_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      oor_q       <= 1'b0;
      act_s_q     <= 1'b0;
      act_c_q     <= 1'b0;
      neg_s_q     <= 1'b0;
      neg_c_q     <= 1'b0;
      outs_q      <= '0;
      n_q         <= '0;
      tol_q       <= TOL_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      oor_q       <= oor_d;
      act_s_q     <= act_s_d;
      act_c_q     <= act_c_d;
      neg_s_q     <= neg_s_d;
      neg_c_q     <= neg_c_d;
      outs_q      <= outs_d;
      n_q         <= n_d;
      if (cfg_valid_i) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
    conv_q  <= conv_d;
    x_q     <= x_d;
    x2_q    <= x2_d;
    mag_s_q <= mag_s_d;
    mag_c_q <= mag_c_d;
    sum_s_q <= sum_s_d;
    sum_c_q <= sum_c_d;
    sin_o_q <= sin_o_d;
    cos_o_q <= cos_o_d;
    oor_o_q <= oor_o_d;
  end

  // the block takes a new angle only from idle; the output register holds a result meanwhile
  assign in_stall_o     = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign sine_value_o   = sin_o_q;
  assign cosine_value_o = cos_o_q;
  assign out_of_range_o = oor_o_q;

endmodule

[rtl/tsc_checker.sv]
// ----------------------------------------------------------------------------
// tsc checker
// port-level checks of the taylor sine cosine core, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "taylor_sine_cosine_core_defines.svh"

module tsc_checker import tsc_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [OUT_W-1:0] sine_value_o,
  input logic signed [OUT_W-1:0] cosine_value_o,
  input logic                    out_of_range_o
);

  logic              sine_ok;
  logic              cosine_ok;
  logic              values_zero;
  logic [2*OUT_W:0]  out_word;

  assign sine_ok     = (sine_value_o <= 32'sd1073741824) && (sine_value_o >= -32'sd1073741824);
  assign cosine_ok   = (cosine_value_o <= 32'sd1073741824) &&
                       (cosine_value_o >= -32'sd1073741824);
  assign values_zero = (sine_value_o == 32'sd0) && (cosine_value_o == 32'sd0);
  assign out_word    = {sine_value_o, cosine_value_o, out_of_range_o};

  // an accepted angle keeps the input closed for at least the next cycle
  `TSC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // out of range results carry zeros
  `TSC_ASSERT_SAME(a_oor_zero, clk_i, rst_ni, out_valid_o && out_of_range_o, values_zero)

  // results saturate to plus or minus one
  `TSC_ASSERT_SAME(a_saturated, clk_i, rst_ni, out_valid_o, sine_ok && cosine_ok)

  // a stalled result holds
  `TSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word))

endmodule

bind taylor_sine_cosine_core tsc_checker u_tsc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .sine_value_o   (sine_value_o),
  .cosine_value_o (cosine_value_o),
  .out_of_range_o (out_of_range_o)
);
